### rtl/sast_pkg.sv
// Package: constants, codes and shared types for the stack allocator.
`timescale 1ns / 1ps

package sast_pkg;

    // Arena geometry
    localparam int ARENA_CHUNKS = 1024;
    localparam int CHUNK_BYTES  = 8;
    localparam int ADDR_W       = $clog2(ARENA_CHUNKS);
    localparam int CHUNK_SH     = $clog2(CHUNK_BYTES);

    // Field widths
    localparam int MODE_W  = 2;
    localparam int SIZE_W  = 14;
    localparam int ID_W    = 16;
    localparam int TOP_W   = 11;
    localparam int CAP_W   = 11;
    localparam int NCH_W   = SIZE_W - CHUNK_SH + 1;
    localparam int SUM_W   = NCH_W + 1;
    localparam int STAT_W  = 2;
    localparam int FREE_W  = 13;
    localparam int HWB_W   = 14;
    localparam int PROD_W  = TOP_W + 1 + CHUNK_SH + 1;

    // Request kinds
    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESIZE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ID   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // Register indexes
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] size_bytes;
        logic [ID_W-1:0]   block_id;
    } t_req;

    typedef struct packed {
        logic [TOP_W-1:0] top;
        logic [ID_W-1:0]  next_id;
        logic [TOP_W-1:0] high_water;
        logic [CAP_W-1:0] cap;
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] start_chunk;
        logic [ID_W-1:0]   new_id;
        logic [STAT_W-1:0] status;
        logic [FREE_W-1:0] free_bytes;
        logic [HWB_W-1:0]  high_water_bytes;
        logic              is_empty;
    } t_rslt;

    typedef struct packed {
        logic [TOP_W-1:0]  top;
        logic [ID_W-1:0]   next_id;
        logic [TOP_W-1:0]  high_water;
        logic              tag_we;
        logic [ADDR_W-1:0] tag_addr;
        logic [ADDR_W-1:0] tag_data;
    } t_upd;

endpackage

### rtl/sast_exec.sv
// Request datapath: next pointer, id, tag write and result for one request.
`timescale 1ns / 1ps

module sast_exec (
    input  sast_pkg::t_req                 i_req,
    input  sast_pkg::t_state               i_st,
    input  logic [sast_pkg::ADDR_W-1:0]    i_tag,
    output sast_pkg::t_upd                 o_upd,
    output sast_pkg::t_rslt                o_rslt
);

    logic [sast_pkg::NCH_W-1:0]  n_chunks;
    logic [sast_pkg::CAP_W-1:0]  cap;
    logic [sast_pkg::ID_W-1:0]   newest;
    logic [sast_pkg::SUM_W-1:0]  alloc_sum;
    logic [sast_pkg::TOP_W-1:0]  old_p1;
    logic [sast_pkg::TOP_W-1:0]  base;
    logic [sast_pkg::TOP_W-1:0]  pop_top;
    logic [sast_pkg::SUM_W-1:0]  res_sum;
    logic [sast_pkg::SUM_W-1:0]  res_end;
    logic [sast_pkg::TOP_W:0]    top_p1;
    logic [sast_pkg::TOP_W:0]    freec;
    logic [sast_pkg::PROD_W-1:0] free_prod;
    logic [sast_pkg::PROD_W-1:0] hw_prod;
    logic [sast_pkg::TOP_W-1:0]  top_nx;
    logic [sast_pkg::TOP_W-1:0]  hw_nx;
    logic                        bump;
    logic [sast_pkg::ADDR_W-1:0] start_chunk;
    logic [sast_pkg::ID_W-1:0]   new_id;
    logic [sast_pkg::STAT_W-1:0] status;

    // Round the byte count up to whole chunks
    assign n_chunks = sast_pkg::NCH_W'(i_req.size_bytes >> sast_pkg::CHUNK_SH)
                    + sast_pkg::NCH_W'(|i_req.size_bytes[sast_pkg::CHUNK_SH-1:0]);

    // Clamp capacity to the arena
    assign cap = (i_st.cap < sast_pkg::CAP_W'(sast_pkg::ARENA_CHUNKS))
               ? i_st.cap : sast_pkg::CAP_W'(sast_pkg::ARENA_CHUNKS);

    assign newest    = i_st.next_id - sast_pkg::ID_W'(1);
    assign alloc_sum = sast_pkg::SUM_W'(n_chunks) + sast_pkg::SUM_W'(i_st.top)
                     + sast_pkg::SUM_W'(1);

    // Locate the newest block's base from its tag, saturating at chunk 0
    assign old_p1  = sast_pkg::TOP_W'(i_tag) + sast_pkg::TOP_W'(1);
    assign base    = (old_p1 <= i_st.top) ? i_st.top - old_p1 : '0;
    assign pop_top = base;
    assign res_end = sast_pkg::SUM_W'(base) + sast_pkg::SUM_W'(n_chunks);
    assign res_sum = res_end + sast_pkg::SUM_W'(2);

    // Decide the request
    always_comb begin
        o_upd         = '0;
        o_upd.top     = i_st.top;
        o_upd.next_id = i_st.next_id;
        start_chunk   = '0;
        new_id        = '0;
        status        = sast_pkg::ST_OK;
        bump          = 1'b0;
        case (i_req.mode)
            sast_pkg::MODE_ALLOC: begin
                if (alloc_sum < sast_pkg::SUM_W'(cap)) begin
                    start_chunk    = i_st.top[sast_pkg::ADDR_W-1:0];
                    new_id         = i_st.next_id;
                    o_upd.tag_we   = 1'b1;
                    o_upd.tag_addr = sast_pkg::ADDR_W'(sast_pkg::SUM_W'(i_st.top)
                                   + sast_pkg::SUM_W'(n_chunks));
                    o_upd.tag_data = n_chunks[sast_pkg::ADDR_W-1:0];
                    o_upd.top      = alloc_sum[sast_pkg::TOP_W-1:0];
                    o_upd.next_id  = i_st.next_id + sast_pkg::ID_W'(1);
                    bump           = 1'b1;
                end else begin
                    status = sast_pkg::ST_NO_SPACE;
                end
            end
            sast_pkg::MODE_RESIZE: begin
                if (i_st.top == '0) begin
                    status = sast_pkg::ST_EMPTY;
                end else if (i_req.block_id != newest) begin
                    status = sast_pkg::ST_BAD_ID;
                end else if (res_sum < sast_pkg::SUM_W'(cap)) begin
                    o_upd.tag_we   = 1'b1;
                    o_upd.tag_addr = res_end[sast_pkg::ADDR_W-1:0];
                    o_upd.tag_data = n_chunks[sast_pkg::ADDR_W-1:0];
                    o_upd.top      = sast_pkg::TOP_W'(res_end + sast_pkg::SUM_W'(1));
                    bump           = 1'b1;
                end else begin
                    status = sast_pkg::ST_NO_SPACE;
                end
            end
            sast_pkg::MODE_FREE: begin
                if (i_req.block_id != newest) begin
                    status = sast_pkg::ST_BAD_ID;
                end else if (i_st.top == '0) begin
                    status = sast_pkg::ST_EMPTY;
                end else begin
                    o_upd.top     = pop_top;
                    o_upd.next_id = newest;
                end
            end
            default: begin
                status = sast_pkg::ST_OK;
            end
        endcase

        // Raise the high-water mark on a successful grow
        if (bump && o_upd.top > i_st.high_water) begin
            o_upd.high_water = o_upd.top;
        end else begin
            o_upd.high_water = i_st.high_water;
        end
    end

    assign top_nx = o_upd.top;
    assign hw_nx  = o_upd.high_water;

    // Report occupancy after the request
    assign top_p1    = (sast_pkg::TOP_W+1)'(top_nx) + (sast_pkg::TOP_W+1)'(1);
    assign freec     = ((sast_pkg::TOP_W+1)'(cap) > top_p1)
                     ? (sast_pkg::TOP_W+1)'(cap) - top_p1 : '0;
    assign free_prod = sast_pkg::PROD_W'(freec) * sast_pkg::PROD_W'(sast_pkg::CHUNK_BYTES);
    assign hw_prod   = (sast_pkg::PROD_W'(hw_nx) + sast_pkg::PROD_W'(1))
                     * sast_pkg::PROD_W'(sast_pkg::CHUNK_BYTES);

    assign o_rslt = {start_chunk, new_id, status,
                     free_prod[sast_pkg::FREE_W-1:0],
                     hw_prod[sast_pkg::HWB_W-1:0],
                     (top_nx == '0)};

endmodule

### rtl/stack_allocator_with_size_tags.sv
// Top level: LIFO stack allocator with size tags over a chunked arena.
//
// Requests enter on the s_axis channel: tuser carries the mode (allocate,
// resize newest, free newest), tdata the byte size and the block id. Each
// request yields exactly one result on the m_axis channel with start chunk,
// new id, status, free bytes, high-water bytes and the empty flag.
// Capacity is set through the APB port (register 0, byte address 0).
//
// Each request passes through accept and execute: the accept cycle issues
// the read of the tag just below the top from the tag memory, and the
// execute state uses the registered tag to update the pointer, id and tag
// and load the result register. A new request is accepted only after the
// previous one has executed, so the tag memory read and the update of one
// request never overlap those of the next.
// A result waiting in the output register does not block the next accept;
// if it is still not taken when the next result is ready, that request
// holds in the execute state until the receiver takes the waiting one.
// Reset (synchronous, active low) empties the stack, clears ids and the
// high-water mark and sets capacity to 1024 chunks. Tag memory contents
// are not cleared; only written entries are ever used.
`timescale 1ns / 1ps

module stack_allocator_with_size_tags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // size_bytes[13:0], block_id[29:14], zero pad
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // start_chunk[9:0], new_id[25:10], status[27:26],
                                        // free_bytes[40:28], high_water_bytes[54:41],
                                        // is_empty[55]
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                             r_state, n_state;
    sast_pkg::t_req                   r_req;
    logic [sast_pkg::TOP_W-1:0]       r_top;
    logic [sast_pkg::ID_W-1:0]        r_next_id;
    logic [sast_pkg::TOP_W-1:0]       r_hw;
    logic [sast_pkg::CAP_W-1:0]       r_cap;
    logic [sast_pkg::ADDR_W-1:0]      r_tag;
    sast_pkg::t_rslt                  r_out;
    logic                             r_out_valid;
    logic [sast_pkg::ADDR_W-1:0]      tag_mem [sast_pkg::ARENA_CHUNKS];

    logic                             in_acc;
    logic                             exec_go;
    logic                             cfg_wr;
    logic [sast_pkg::TOP_W-1:0]       top_m1;
    sast_pkg::t_state                 st;
    sast_pkg::t_upd                   upd;
    sast_pkg::t_rslt                  rslt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign exec_go       = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);
    assign top_m1        = r_top - sast_pkg::TOP_W'(1);

    assign st.top        = r_top;
    assign st.next_id    = r_next_id;
    assign st.high_water = r_hw;
    assign st.cap        = r_cap;

    sast_exec u_exec (
        .i_req  (r_req),
        .i_st   (st),
        .i_tag  (r_tag),
        .o_upd  (upd),
        .o_rslt (rslt)
    );

    // Sequence: accept, then execute when the result slot frees
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_EXEC;
            S_EXEC:  if (exec_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req.mode       <= s_axis_tuser;
            r_req.size_bytes <= s_axis_tdata[13:0];
            r_req.block_id   <= s_axis_tdata[29:14];
        end
    end

    // Tag memory: read below the top at accept, write back on execute
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tag <= tag_mem[top_m1[sast_pkg::ADDR_W-1:0]];
        end
        if (exec_go && upd.tag_we) begin
            tag_mem[upd.tag_addr] <= upd.tag_data;
        end
    end

    // Advance the stack state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= '0;
            r_next_id <= '0;
            r_hw      <= '0;
        end else if (exec_go) begin
            r_top     <= upd.top;
            r_next_id <= upd.next_id;
            r_hw      <= upd.high_water;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_out <= rslt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.is_empty, r_out.high_water_bytes, r_out.free_bytes,
                            r_out.status, r_out.new_id, r_out.start_chunk};

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == sast_pkg::REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= sast_pkg::CAP_W'(1024);
        end else if (cfg_wr) begin
            r_cap <= pwdata[sast_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == sast_pkg::REG_CAPACITY) ? 32'(r_cap) : 32'd0;

    // Checks
    a_acc_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && !m_axis_tready) |=>
        (r_state == S_EXEC && $stable(r_top) && $stable(r_next_id)))
        else $error("request executed over an untaken result");

    a_hw_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw >= r_top)
        else $error("high-water mark below top");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < sast_pkg::TOP_W'(sast_pkg::ARENA_CHUNKS))
        else $error("top pointer beyond arena");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result produced without an executing request");

endmodule
